FILE: rtl/core/lpr_pkg.sv
// Shared types and constants of the LRU page replacement block.
`default_nettype none
package lpr_pkg;
	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 16;
	localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int TS_W       = 32;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [TS_W-1:0]      ts_t;
	typedef logic [15:0]          page_fld_t;
	typedef logic [3:0]           slot_fld_t;
	typedef logic [4:0]           cfg_fld_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_LAST   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	typedef struct packed {
		logic  clear;
		logic  valid;
		slot_t idx;
		cnt_t  limit;
	} scan_ctl_t;

	typedef struct packed {
		logic  hit;
		slot_t hit_slot;
		slot_t best_slot;
		ts_t   best_ts;
		page_t best_page;
	} scan_res_t;
endpackage
`default_nettype wire

FILE: rtl/core/lpr_scan.sv
// Frame scan unit: one page compare and one timestamp compare per frame and cycle.
`default_nettype none
module lpr_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  lpr_pkg::scan_ctl_t ctl,
	input  lpr_pkg::page_t    page,
	input  lpr_pkg::page_t    frame_page,
	input  lpr_pkg::ts_t      frame_ts,
	output lpr_pkg::scan_res_t res
);
	logic           hit_q;
	lpr_pkg::slot_t hit_slot_q;
	lpr_pkg::slot_t best_slot_q;
	lpr_pkg::ts_t   best_ts_q;
	lpr_pkg::page_t best_page_q;
	logic in_range;
	logic take_hit;
	logic take_min;

	assign in_range = lpr_pkg::cnt_t'(ctl.idx) < ctl.limit;
	assign take_hit = ctl.valid && in_range && !hit_q && (frame_page == page);
	// A strict compare keeps the lowest slot on equal timestamps.
	assign take_min = ctl.valid && ((ctl.idx == '0) || (frame_ts < best_ts_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
		end else if (take_hit) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_slot_q <= ctl.idx;
		end
		if (take_min) begin
			best_slot_q <= ctl.idx;
			best_ts_q   <= frame_ts;
			best_page_q <= frame_page;
		end
	end

	assign res = {hit_q, hit_slot_q, best_slot_q, best_ts_q, best_page_q};
endmodule
`default_nettype wire

FILE: rtl/core/lru_page_replacement.sv
// Top level of the LRU page replacement block with timestamped frames.
// One page reference is taken when start is high and busy is low; busy then stays high while
// the frame store is swept one frame per cycle through a single compare unit, which looks for
// a hit and for the oldest frame in the same pass. The sweep covers the N active frames; then the
// last read drains in the LAST state and the frame store is written in the UPDATE state. The
// result word, registered from the UPDATE state, appears for exactly one cycle
// with done high and cannot be held off by the receiver. The frame count is written through the
// cfg channel, which is always ready, and should be written only right after reset.
`default_nettype none
module lru_page_replacement (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  lpr_pkg::page_fld_t    page_number,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  lpr_pkg::cfg_fld_t     cfg_data,
	output logic                  done,
	output logic                  hit,
	output lpr_pkg::slot_fld_t    frame_slot,
	output logic                  evicted_valid,
	output lpr_pkg::page_fld_t    evicted_page,
	output logic [31:0]           fault_total
);
	lpr_pkg::state_t    state_q;
	lpr_pkg::cfg_fld_t  frames_cfg_q;
	lpr_pkg::cnt_t      nfr;
	lpr_pkg::cnt_t      nfr_q;
	lpr_pkg::cnt_t      limit_q;
	lpr_pkg::cnt_t      filled_q;
	lpr_pkg::slot_t     idx_q;
	lpr_pkg::slot_t     last_idx_q;
	lpr_pkg::ts_t       clock_q;
	lpr_pkg::ts_t       fault_q;
	lpr_pkg::page_t     page_q;
	logic               valid_s1;
	lpr_pkg::slot_t     idx_s1;
	lpr_pkg::page_t     page_s1;
	lpr_pkg::ts_t       ts_s1;
	lpr_pkg::page_t     frame_page_mem [lpr_pkg::MAX_FRAMES];
	lpr_pkg::ts_t       frame_ts_mem   [lpr_pkg::MAX_FRAMES];
	lpr_pkg::scan_ctl_t scan_ctl;
	lpr_pkg::scan_res_t scan_res;
	logic               accept;
	logic               upd_fill;
	logic               upd_evict;
	lpr_pkg::slot_t     upd_slot;
	logic               done_q;
	logic               hit_q;
	lpr_pkg::slot_fld_t slot_q;
	logic               ev_valid_q;
	lpr_pkg::page_fld_t ev_page_q;

	assign accept    = start && (state_q == lpr_pkg::ST_IDLE);
	assign busy      = (state_q != lpr_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	// A frame count of zero acts as one, and one above the store size as the store size.
	always_comb begin
		if (frames_cfg_q == '0) begin
			nfr = lpr_pkg::cnt_t'(1);
		end else if (int'(frames_cfg_q) > lpr_pkg::MAX_FRAMES) begin
			nfr = lpr_pkg::cnt_t'(lpr_pkg::MAX_FRAMES);
		end else begin
			nfr = lpr_pkg::cnt_t'(frames_cfg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_cfg_q <= lpr_pkg::cfg_fld_t'(16);
		end else if (cfg_valid && cfg_ready) begin
			frames_cfg_q <= cfg_data;
		end
	end

	// Sequencer: sweep the active frames, let the last read drain, then update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lpr_pkg::ST_IDLE;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == lpr_pkg::ST_SCAN);
			case (state_q)
				lpr_pkg::ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						state_q <= lpr_pkg::ST_SCAN;
					end
				end
				lpr_pkg::ST_SCAN: begin
					if (idx_q == last_idx_q) begin
						state_q <= lpr_pkg::ST_LAST;
					end else begin
						idx_q <= idx_q + lpr_pkg::slot_t'(1);
					end
				end
				lpr_pkg::ST_LAST: begin
					state_q <= lpr_pkg::ST_UPDATE;
				end
				lpr_pkg::ST_UPDATE: begin
					state_q <= lpr_pkg::ST_IDLE;
				end
				default: begin
					state_q <= lpr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			page_q     <= lpr_pkg::page_t'(page_number);
			nfr_q      <= nfr;
			last_idx_q <= lpr_pkg::slot_t'(nfr - lpr_pkg::cnt_t'(1));
			limit_q    <= (filled_q < nfr) ? filled_q : nfr;
		end
	end

	always_comb begin
		upd_slot  = scan_res.best_slot;
		upd_fill  = 1'b0;
		upd_evict = 1'b0;
		if (scan_res.hit) begin
			upd_slot = scan_res.hit_slot;
		end else if (filled_q < nfr_q) begin
			upd_slot = lpr_pkg::slot_t'(filled_q);
			upd_fill = 1'b1;
		end else begin
			upd_evict = 1'b1;
		end
	end

	// Frame store: one read per cycle for the sweep, one write in the update cycle.
	always_ff @(posedge clk) begin
		if (state_q == lpr_pkg::ST_UPDATE) begin
			frame_page_mem[upd_slot] <= page_q;
			frame_ts_mem[upd_slot]   <= clock_q;
		end
		page_s1 <= frame_page_mem[idx_q];
		ts_s1   <= frame_ts_mem[idx_q];
	end

	assign scan_ctl.clear = accept;
	assign scan_ctl.valid = valid_s1;
	assign scan_ctl.idx   = idx_s1;
	assign scan_ctl.limit = limit_q;

	lpr_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.page       (page_q),
		.frame_page (page_s1),
		.frame_ts   (ts_s1),
		.res        (scan_res)
	);

	// Use clock and fault count both stop at all ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			clock_q  <= '0;
			fault_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == lpr_pkg::ST_UPDATE);
			if (accept && (clock_q != '1)) begin
				clock_q <= clock_q + lpr_pkg::ts_t'(1);
			end
			if (state_q == lpr_pkg::ST_UPDATE) begin
				if (upd_fill) begin
					filled_q <= filled_q + lpr_pkg::cnt_t'(1);
				end
				if (!scan_res.hit && (fault_q != '1)) begin
					fault_q <= fault_q + lpr_pkg::ts_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lpr_pkg::ST_UPDATE) begin
			hit_q      <= scan_res.hit;
			slot_q     <= lpr_pkg::slot_fld_t'(upd_slot);
			ev_valid_q <= upd_evict;
			ev_page_q  <= upd_evict ? lpr_pkg::page_fld_t'(scan_res.best_page) : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_slot    = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_total   = fault_q;
endmodule
`default_nettype wire

FILE: rtl/core/lpr_checker.sv
// Port-level checks for the LRU page replacement block, bound to the top level.
`default_nettype none
module lpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        hit,
	input logic        evicted_valid,
	input logic [15:0] evicted_page,
	input logic [31:0] fault_total
);
	// A word is only delivered once the block has gone back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word delivered while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted reference did not raise busy");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> !evicted_valid)
		else $error("hit reported together with an eviction");

	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !evicted_valid) |-> (evicted_page == 16'd0))
		else $error("evicted page not zero without an eviction");

	a_fault_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (fault_total != 32'd0))
		else $error("page fault reported with a zero fault count");
endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.evicted_valid (evicted_valid),
	.evicted_page  (evicted_page),
	.fault_total   (fault_total)
);
`default_nettype wire
